// File: sv/tdcmu_pkg.sv
`default_nettype none

package tdcmu_pkg;

	// Hit channels per chip and fine counter bins (power of two)
	localparam int NUM_CHANNELS   = 4;
	localparam int FINE_BINS_LOG2 = 7;
	localparam int FINE_BINS      = 1 << FINE_BINS_LOG2;

	// Rising time slots: two chips, four channel positions each
	localparam int SLOT_COUNT = 8;

	localparam int EPOCH_W = 24;
	localparam int STAMP_W = 19;
	localparam int TS_W    = EPOCH_W + STAMP_W;
	localparam int OT_W    = TS_W + 1;

	// Marker words, upper half
	localparam logic [15:0] MARK_DESEL_A = 16'habcd;
	localparam logic [15:0] MARK_DESEL_B = 16'hcccc;
	localparam logic [15:0] MARK_CHIP0   = 16'haaaa;
	localparam logic [15:0] MARK_CHIP1   = 16'hbbbb;

	localparam logic [1:0] CHIP_NONE = 2'd3;

	// Error ids above the max are reported as the clamp code
	localparam logic [6:0] ERR_MAX   = 7'd19;
	localparam logic [4:0] ERR_CLAMP = 5'd23;

	typedef enum logic [2:0] {
		KIND_NONE     = 3'd0,
		KIND_HIT      = 3'd1,
		KIND_ERROR    = 3'd2,
		KIND_NO_CHIP  = 3'd3,
		KIND_BAD_TYPE = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		MSG_EPOCH     = 2'd0,
		MSG_SLOW_CTRL = 2'd1,
		MSG_ERROR     = 2'd2,
		MSG_HIT       = 2'd3
	} msg_t;

	typedef enum logic [1:0] {
		CFG_MODE      = 2'd0,
		CFG_TOT_MULT  = 2'd1,
		CFG_CHIP_MASK = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic       mode_32bit;
		logic [7:0] tot_multiplier;
		logic [1:0] chip_enable_mask;
	} cfg_t;

	// Result word; over_threshold holds a two's complement value
	typedef struct packed {
		logic [4:0]      error_code;
		logic            over_threshold_valid;
		logic [OT_W-1:0] over_threshold;
		logic            time_valid;
		logic [TS_W-1:0] timestamp;
		logic [6:0]      falling_fine_bin;
		logic [6:0]      fine_bin;
		logic            falling;
		logic [1:0]      channel;
		logic            chip_id;
		kind_t           kind;
	} result_t;

endpackage

`default_nettype wire

// File: sv/tdcmu_cfg.sv
`default_nettype none

module tdcmu_cfg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [7:0]      cfg_data,
	output tdcmu_pkg::cfg_t      cfg
);

	logic       mode_q;
	logic [7:0] mult_q;
	logic [1:0] mask_q;

	// Writes are always accepted; cfg_ready is tied high
	assign cfg_ready = 1'b1;

	// Register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			mult_q <= 8'd1;
			mask_q <= 2'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				tdcmu_pkg::CFG_MODE:      mode_q <= cfg_data[0];
				tdcmu_pkg::CFG_TOT_MULT:  mult_q <= cfg_data;
				tdcmu_pkg::CFG_CHIP_MASK: mask_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg.mode_32bit       = mode_q;
	assign cfg.tot_multiplier   = mult_q;
	assign cfg.chip_enable_mask = mask_q;

endmodule

`default_nettype wire

// File: sv/tdcmu_decode.sv
`default_nettype none

module tdcmu_decode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tdcmu_pkg::cfg_t   cfg,
	input  wire logic              item_valid,
	input  wire logic [31:0]       item_word,
	input  wire logic              item_first,
	output logic                   advance,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output tdcmu_pkg::result_t     result
);

	localparam logic [2:0] CHAN_LIMIT = 3'(tdcmu_pkg::NUM_CHANNELS);
	localparam int         SUM_W      = 17;

	// Buffer state
	logic [1:0]                           chip_q;
	logic [tdcmu_pkg::EPOCH_W-1:0]        epoch_q;
	logic                                 fault_q;
	logic [tdcmu_pkg::SLOT_COUNT-1:0]     known_q;
	logic [tdcmu_pkg::TS_W-1:0]           rise_q [tdcmu_pkg::SLOT_COUNT];

	logic                                 out_valid_q;
	tdcmu_pkg::result_t                   result_q;

	logic                                 fire;
	tdcmu_pkg::result_t                   res_d;
	logic [1:0]                           chip_d;
	logic [tdcmu_pkg::EPOCH_W-1:0]        epoch_d;
	logic                                 fault_d;
	logic [tdcmu_pkg::SLOT_COUNT-1:0]     known_d;
	logic                                 wr_rise;
	logic [2:0]                           slot;
	logic [tdcmu_pkg::TS_W-1:0]           full;

	logic [1:0]                           eff_chip;
	logic [tdcmu_pkg::EPOCH_W-1:0]        eff_epoch;
	logic                                 eff_fault;
	logic [15:0]                          upper;
	logic [1:0]                           bound;
	logic [1:0]                           mtype;
	logic [1:0]                           chid;
	logic [6:0]                           fine;
	logic [tdcmu_pkg::STAMP_W-1:0]        stamp;
	logic [15:0]                          span;
	logic [SUM_W-1:0]                     fsum;
	logic                                 edge_bit;

	assign advance = !out_valid_q || out_ready;
	assign fire    = item_valid && advance;

	// Field extraction for both formats
	always_comb begin
		upper = item_word[31:16];
		bound = cfg.chip_enable_mask[1] ? 2'd2 : (cfg.chip_enable_mask[0] ? 2'd1 : 2'd0);
		mtype = cfg.mode_32bit ? item_word[31:30] : item_word[23:22];
		span  = {8'b0, item_word[7:0]} * {8'b0, cfg.tot_multiplier};
		if (cfg.mode_32bit) begin
			chid     = item_word[28:27];
			fine     = item_word[14:8];
			stamp    = item_word[26:8];
			edge_bit = 1'b0;
		end else begin
			chid     = item_word[21:20];
			fine     = item_word[6:0];
			stamp    = item_word[18:0];
			edge_bit = item_word[19];
		end
		fsum = SUM_W'(fine) + SUM_W'(span);
	end

	// Message decode and next state
	always_comb begin
		eff_chip  = item_first ? tdcmu_pkg::CHIP_NONE : chip_q;
		eff_epoch = item_first ? '0 : epoch_q;
		eff_fault = item_first ? 1'b0 : fault_q;

		res_d   = '0;
		chip_d  = eff_chip;
		epoch_d = eff_epoch;
		fault_d = eff_fault;
		known_d = item_first ? '0 : known_q;
		wr_rise = 1'b0;
		slot    = {eff_chip[0], chid};
		full    = {eff_epoch, stamp};

		if (eff_fault) begin
			// rest of buffer skipped
		end else if (upper == tdcmu_pkg::MARK_DESEL_A || upper == tdcmu_pkg::MARK_DESEL_B) begin
			chip_d = tdcmu_pkg::CHIP_NONE;
		end else if (upper == tdcmu_pkg::MARK_CHIP0) begin
			chip_d  = 2'd0;
			epoch_d = '0;
		end else if (upper == tdcmu_pkg::MARK_CHIP1) begin
			chip_d  = 2'd1;
			epoch_d = '0;
		end else if (eff_chip >= bound) begin
			res_d.kind = tdcmu_pkg::KIND_NO_CHIP;
			fault_d    = 1'b1;
		end else if (cfg.chip_enable_mask[eff_chip[0]]) begin
			case (mtype)
				tdcmu_pkg::MSG_EPOCH: begin
					if (cfg.mode_32bit) epoch_d = item_word[24:1];
					else epoch_d = {3'b0, item_word[21:1]};
				end
				tdcmu_pkg::MSG_SLOW_CTRL: begin
					if (!cfg.mode_32bit) begin
						res_d.kind    = tdcmu_pkg::KIND_BAD_TYPE;
						res_d.chip_id = eff_chip[0];
						fault_d       = 1'b1;
					end
				end
				tdcmu_pkg::MSG_ERROR: begin
					res_d.kind       = tdcmu_pkg::KIND_ERROR;
					res_d.chip_id    = eff_chip[0];
					res_d.error_code = (item_word[6:0] > tdcmu_pkg::ERR_MAX) ?
						tdcmu_pkg::ERR_CLAMP : item_word[4:0];
				end
				default: begin
					if ({1'b0, chid} < CHAN_LIMIT) begin
						res_d.kind     = tdcmu_pkg::KIND_HIT;
						res_d.chip_id  = eff_chip[0];
						res_d.channel  = chid;
						res_d.falling  = edge_bit;
						res_d.fine_bin = fine;
						if (cfg.mode_32bit)
							res_d.falling_fine_bin =
								7'(fsum & SUM_W'(tdcmu_pkg::FINE_BINS - 1));
						if (eff_epoch != '0) begin
							res_d.timestamp  = full;
							res_d.time_valid = 1'b1;
							if (cfg.mode_32bit) begin
								wr_rise                    = 1'b1;
								res_d.over_threshold       = tdcmu_pkg::OT_W'(span);
								res_d.over_threshold_valid = 1'b1;
							end else if (!edge_bit) begin
								wr_rise = 1'b1;
							end else if (known_d[slot]) begin
								res_d.over_threshold = tdcmu_pkg::OT_W'(full) -
									tdcmu_pkg::OT_W'(rise_q[slot]);
								res_d.over_threshold_valid = 1'b1;
							end
						end
					end
				end
			endcase
		end
		if (wr_rise) known_d[slot] = 1'b1;
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_q      <= tdcmu_pkg::CHIP_NONE;
			epoch_q     <= '0;
			fault_q     <= 1'b0;
			known_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				chip_q  <= chip_d;
				epoch_q <= epoch_d;
				fault_q <= fault_d;
				known_q <= known_d;
			end
			if (fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload: result word and rising times
	always_ff @(posedge clk) begin
		if (fire) result_q <= res_d;
		if (fire && wr_rise) rise_q[slot] <= full;
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	// Fault stays until a new buffer opens
	assert property (@(posedge clk) disable iff (!arst_n)
		fault_q && !(fire && item_first) |=> fault_q)
		else $error("buffer fault cleared without first word");

	// A fault result always arms the skip
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res_d.kind == tdcmu_pkg::KIND_NO_CHIP ||
			res_d.kind == tdcmu_pkg::KIND_BAD_TYPE) |=> fault_q)
		else $error("fault result without buffer fault");

	// Time over threshold needs a valid timestamp
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.over_threshold_valid |-> result_q.time_valid)
		else $error("over_threshold valid without time");

	// Empty results carry no timing
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.kind == tdcmu_pkg::KIND_NONE |->
			!result_q.time_valid && !result_q.over_threshold_valid)
		else $error("empty result with timing fields");

endmodule

`default_nettype wire

// File: sv/tdc_message_unpacker.sv
// Each accepted word passes the input register, then the result register.
// Throughput: one word per cycle unless m_tready stalls; each word is decoded in the
// single pass between the two registers, which also updates the epoch and rising times.
// Reset (arst_n low, asynchronous): no chip selected, epoch zero, fault cleared, rising
// times unknown, both pipeline registers empty, 24-bit mode, multiplier 1, mask 3.
`default_nettype none

module tdc_message_unpacker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// Input words
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [31:0]   s_tdata,   // word[31:0]
	input  wire logic          s_tuser,   // first_word[0]
	// Result words
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// chip_id[0], channel[2:1], falling[3], fine_bin[10:4], falling_fine_bin[17:11],
	// timestamp[60:18], time_valid[61], over_threshold[105:62],
	// over_threshold_valid[106], error_code[111:107]
	output logic [111:0]       m_tdata,
	output logic [2:0]         m_tuser,   // kind[2:0]
	// Register writes
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_data
);

	tdcmu_pkg::cfg_t    cfg;
	tdcmu_pkg::result_t result;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        first_s1;
	logic        advance;

	tdcmu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register: loads whenever its word moves on or it is empty
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	tdcmu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (valid_s1),
		.item_word  (word_s1),
		.item_first (first_s1),
		.advance    (advance),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.result     (result)
	);

	// Pack result word
	assign m_tuser = result.kind;
	assign m_tdata = {result.error_code, result.over_threshold_valid, result.over_threshold,
		result.time_valid, result.timestamp, result.falling_fine_bin, result.fine_bin,
		result.falling, result.channel, result.chip_id};

endmodule

`default_nettype wire

// File: test/tb_tdc_message_unpacker.sv
`default_nettype none

module tb_tdc_message_unpacker;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 134;
	localparam int SETTLE      = 10;
	localparam int PRINT_CAP   = 200;

	// One input word with its buffer-start flag
	typedef struct packed {
		logic        first;
		logic [31:0] word;
	} in_word_t;

	// Register settings per random phase
	localparam logic       PH_MODE [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
	localparam logic [7:0] PH_MULT [PHASES] = '{8'd1, 8'd255, 8'd17, 8'd1, 8'd128, 8'd255,
		8'd93, 8'd1};
	localparam logic [1:0] PH_MASK [PHASES] = '{2'd3, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd2};

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic [31:0]  s_tdata   = '0;
	logic         s_tuser   = 1'b0;
	logic         m_tready  = 1'b0;
	logic         cfg_valid = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [7:0]   cfg_data  = '0;
	logic         s_tready;
	logic         m_tvalid;
	logic [111:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_ready;

	tdc_message_unpacker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Decoder state mirrored by the testbench
	logic        mode32;
	logic [7:0]  tot_mult;
	logic [1:0]  chip_mask;
	logic [1:0]  sel_chip;
	logic [23:0] epoch_now;
	logic        faulted;
	logic [42:0] rise_time  [tdcmu_pkg::SLOT_COUNT];
	logic        rise_known [tdcmu_pkg::SLOT_COUNT];

	in_word_t           word_q[$];
	tdcmu_pkg::result_t decoded_q[$];

	int fail_count    = 0;
	int cycle_count   = 0;
	int idle_mode     = 0;
	int words_in      = 0;
	int results_in    = 0;
	int hit_count     = 0;
	int tot_count     = 0;
	int err_count     = 0;
	int fault_count   = 0;
	int setting_count = 1;

	task automatic report_error(input string msg);
		if (fail_count < PRINT_CAP)
			$display("t=%0t mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic void clear_buffer();
		sel_chip  = tdcmu_pkg::CHIP_NONE;
		epoch_now = '0;
		faulted   = 1'b0;
		for (int i = 0; i < tdcmu_pkg::SLOT_COUNT; i++) begin
			rise_time[i]  = '0;
			rise_known[i] = 1'b0;
		end
	endfunction

	// Expected result word for one input word; updates the mirrored state
	function automatic tdcmu_pkg::result_t decode_word(input logic [31:0] w, input logic first);
		tdcmu_pkg::result_t r;
		logic [15:0]        upper;
		logic [1:0]         bound;
		tdcmu_pkg::msg_t    mtype;
		logic [1:0]         chid;
		logic [6:0]         fine;
		logic [6:0]         err;
		logic [18:0]        stamp;
		logic [2:0]         slot;
		logic [42:0]        full;
		logic [15:0]        span;
		logic               fall_edge;
		r = '0;
		if (first)
			clear_buffer();
		if (faulted)
			return r;

		// Chip select and deselect markers
		upper = w[31:16];
		if (upper == tdcmu_pkg::MARK_DESEL_A || upper == tdcmu_pkg::MARK_DESEL_B) begin
			sel_chip = tdcmu_pkg::CHIP_NONE;
			return r;
		end
		if (upper == tdcmu_pkg::MARK_CHIP0 || upper == tdcmu_pkg::MARK_CHIP1) begin
			sel_chip  = (upper == tdcmu_pkg::MARK_CHIP1) ? 2'd1 : 2'd0;
			epoch_now = '0;
			return r;
		end

		bound = chip_mask[1] ? 2'd2 : (chip_mask[0] ? 2'd1 : 2'd0);
		if (sel_chip >= bound) begin
			r.kind  = tdcmu_pkg::KIND_NO_CHIP;
			faulted = 1'b1;
			return r;
		end
		if (!chip_mask[sel_chip[0]])
			return r;

		mtype = tdcmu_pkg::msg_t'(mode32 ? w[31:30] : w[23:22]);
		case (mtype)
			tdcmu_pkg::MSG_EPOCH: begin
				epoch_now = mode32 ? w[24:1] : {3'b000, w[21:1]};
			end
			tdcmu_pkg::MSG_SLOW_CTRL: begin
				// only the 24-bit format lacks this type
				if (!mode32) begin
					r.kind    = tdcmu_pkg::KIND_BAD_TYPE;
					r.chip_id = sel_chip[0];
					faulted   = 1'b1;
				end
			end
			tdcmu_pkg::MSG_ERROR: begin
				err          = w[6:0];
				r.kind       = tdcmu_pkg::KIND_ERROR;
				r.chip_id    = sel_chip[0];
				r.error_code = (err > tdcmu_pkg::ERR_MAX) ? tdcmu_pkg::ERR_CLAMP : err[4:0];
			end
			default: begin
				chid = mode32 ? w[28:27] : w[21:20];
				if (chid >= tdcmu_pkg::NUM_CHANNELS)
					return r;
				slot      = {sel_chip[0], chid};
				r.kind    = tdcmu_pkg::KIND_HIT;
				r.chip_id = sel_chip[0];
				r.channel = chid;
				if (mode32) begin
					fine  = w[14:8];
					stamp = w[26:8];
					span  = 16'(w[7:0]) * 16'(tot_mult);
					r.fine_bin         = fine;
					r.falling_fine_bin = 7'(16'(fine) + span);
					if (epoch_now != '0) begin
						full                   = {epoch_now, stamp};
						rise_time[slot]        = full;
						rise_known[slot]       = 1'b1;
						r.timestamp            = full;
						r.time_valid           = 1'b1;
						r.over_threshold       = 44'(span);
						r.over_threshold_valid = 1'b1;
					end
				end else begin
					fall_edge  = w[19];
					fine       = w[6:0];
					stamp      = w[18:0];
					r.falling  = fall_edge;
					r.fine_bin = fine;
					if (epoch_now != '0) begin
						full         = {epoch_now, stamp};
						r.timestamp  = full;
						r.time_valid = 1'b1;
						if (!fall_edge) begin
							rise_time[slot]  = full;
							rise_known[slot] = 1'b1;
						end else if (rise_known[slot]) begin
							r.over_threshold       = {1'b0, full} - {1'b0, rise_time[slot]};
							r.over_threshold_valid = 1'b1;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic bit sender_gap();
		case (idle_mode)
			0:       return $urandom_range(0, 99) < 24;
			1:       return $urandom_range(0, 99) < 67;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (idle_mode)
			0:       return $urandom_range(0, 99) < 67;
			1:       return $urandom_range(0, 99) < 24;
			default: return 1'b0;
		endcase
	endfunction

	// Driver: predicts each accepted word, then presents the next one
	always @(posedge clk or negedge arst_n) begin : driver
		in_word_t           nxt;
		tdcmu_pkg::result_t exp_r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				exp_r = decode_word(s_tdata, s_tuser);
				decoded_q = {decoded_q, exp_r};
				words_in++;
				case (exp_r.kind)
					tdcmu_pkg::KIND_HIT: begin
						hit_count++;
						if (exp_r.over_threshold_valid)
							tot_count++;
					end
					tdcmu_pkg::KIND_ERROR:                         err_count++;
					tdcmu_pkg::KIND_NO_CHIP, tdcmu_pkg::KIND_BAD_TYPE: fault_count++;
					default: ;
				endcase
			end
			if (!s_tvalid || s_tready) begin
				if (word_q.size() != 0 && !sender_gap()) begin
					nxt = word_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.word;
					s_tuser  <= nxt.first;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : monitor
		tdcmu_pkg::result_t got;
		tdcmu_pkg::result_t exp_r;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = tdcmu_pkg::result_t'({m_tdata, m_tuser});
				results_in++;
				if (decoded_q.size() == 0) begin
					report_error($sformatf("result %0d with nothing pending, kind %0d",
						results_in, got.kind));
				end else begin
					exp_r = decoded_q.pop_front();
					if (got.kind !== exp_r.kind)
						report_error($sformatf("result %0d kind %0d, expected %0d",
							results_in, got.kind, exp_r.kind));
					if (got.chip_id !== exp_r.chip_id)
						report_error($sformatf("result %0d chip_id %0d, expected %0d",
							results_in, got.chip_id, exp_r.chip_id));
					if (got.channel !== exp_r.channel)
						report_error($sformatf("result %0d channel %0d, expected %0d",
							results_in, got.channel, exp_r.channel));
					if (got.falling !== exp_r.falling)
						report_error($sformatf("result %0d falling %0d, expected %0d",
							results_in, got.falling, exp_r.falling));
					if (got.fine_bin !== exp_r.fine_bin)
						report_error($sformatf("result %0d fine_bin %0d, expected %0d",
							results_in, got.fine_bin, exp_r.fine_bin));
					if (got.falling_fine_bin !== exp_r.falling_fine_bin)
						report_error($sformatf("result %0d falling_fine_bin %0d, expected %0d",
							results_in, got.falling_fine_bin, exp_r.falling_fine_bin));
					if (got.timestamp !== exp_r.timestamp)
						report_error($sformatf("result %0d timestamp %h, expected %h",
							results_in, got.timestamp, exp_r.timestamp));
					if (got.time_valid !== exp_r.time_valid)
						report_error($sformatf("result %0d time_valid %0d, expected %0d",
							results_in, got.time_valid, exp_r.time_valid));
					if (got.over_threshold !== exp_r.over_threshold)
						report_error($sformatf("result %0d over_threshold %h, expected %h",
							results_in, got.over_threshold, exp_r.over_threshold));
					if (got.over_threshold_valid !== exp_r.over_threshold_valid)
						report_error($sformatf("result %0d over_threshold_valid %0d, expected %0d",
							results_in, got.over_threshold_valid, exp_r.over_threshold_valid));
					if (got.error_code !== exp_r.error_code)
						report_error($sformatf("result %0d error_code %0d, expected %0d",
							results_in, got.error_code, exp_r.error_code));
				end
			end
			m_tready <= !receiver_stall();
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped at cycle limit, %0d results still pending", decoded_q.size());
			$display("[tdc_message_unpacker] ERROR");
			$finish;
		end
	end

	task automatic push_word(input logic [31:0] w, input logic first);
		in_word_t it;
		it.word  = w;
		it.first = first;
		word_q = {word_q, it};
	endtask

	// Wait until every word is sent and every result has come back
	task automatic drain();
		while (word_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input tdcmu_pkg::cfg_index_t idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tdcmu_pkg::CFG_MODE:      mode32    = val[0];
			tdcmu_pkg::CFG_TOT_MULT:  tot_mult  = val;
			tdcmu_pkg::CFG_CHIP_MASK: chip_mask = val[1:0];
			default: ;
		endcase
	endtask

	// Random word of a given message type, with occasional extreme epochs
	function automatic logic [31:0] make_msg(input tdcmu_pkg::msg_t t, input logic m32);
		logic [31:0] w;
		int pick;
		w    = $urandom();
		pick = $urandom_range(0, 15);
		if (m32) begin
			w[31:30] = t;
			if (t == tdcmu_pkg::MSG_EPOCH && pick == 0) w[24:1] = '0;
			if (t == tdcmu_pkg::MSG_EPOCH && pick == 1) w[24:1] = '1;
		end else begin
			w[23:22] = t;
			if (t == tdcmu_pkg::MSG_EPOCH && pick == 0) w[21:1] = '0;
			if (t == tdcmu_pkg::MSG_EPOCH && pick == 1) w[21:1] = '1;
		end
		return w;
	endfunction

	function automatic logic [31:0] make_marker(input logic [15:0] mark);
		logic [15:0] low;
		low = 16'($urandom());
		return {mark, low};
	endfunction

	// Buffers that mostly open with a chip marker and an epoch, plus some noise
	task automatic fill_phase(input int count, input logic m32);
		int added;
		int len;
		int pick;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 99) < 12) begin
				push_word($urandom(), $urandom_range(0, 7) == 0);
				added++;
			end else begin
				len = $urandom_range(3, 24);
				if ($urandom_range(0, 9) == 0)
					push_word(make_msg(tdcmu_pkg::MSG_HIT, m32), 1'b1);
				else
					push_word(make_marker($urandom_range(0, 1) ?
						tdcmu_pkg::MARK_CHIP1 : tdcmu_pkg::MARK_CHIP0), 1'b1);
				if ($urandom_range(0, 9) != 0)
					push_word(make_msg(tdcmu_pkg::MSG_EPOCH, m32), 1'b0);
				for (int i = 2; i < len; i++) begin
					pick = $urandom_range(0, 99);
					if (pick < 62)
						push_word(make_msg(tdcmu_pkg::MSG_HIT, m32), 1'b0);
					else if (pick < 72)
						push_word(make_msg(tdcmu_pkg::MSG_EPOCH, m32), 1'b0);
					else if (pick < 84)
						push_word(make_msg(tdcmu_pkg::MSG_ERROR, m32), 1'b0);
					else if (pick < 91)
						push_word(make_marker($urandom_range(0, 1) ?
							tdcmu_pkg::MARK_CHIP1 : tdcmu_pkg::MARK_CHIP0), 1'b0);
					else if (pick < 94)
						push_word(make_marker($urandom_range(0, 1) ?
							tdcmu_pkg::MARK_DESEL_B : tdcmu_pkg::MARK_DESEL_A), 1'b0);
					else if (pick < 97)
						push_word(make_msg(tdcmu_pkg::MSG_SLOW_CTRL, m32), 1'b0);
					else
						push_word($urandom(), 1'b0);
				end
				added += len;
			end
		end
	endtask

	initial begin
		mode32    = 1'b0;
		tot_mult  = 8'd1;
		chip_mask = 2'd3;
		clear_buffer();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// 24-bit format at reset settings
		push_word({tdcmu_pkg::MARK_CHIP0, 16'h0000}, 1'b1);
		push_word(32'h00f7ffff, 1'b0);                       // hit before any epoch
		push_word(32'h003ffffe, 1'b0);                       // largest 21-bit epoch
		push_word({8'h00, 2'b11, 2'd3, 1'b0, 19'h00000}, 1'b0); // rising, channel 3
		push_word({8'h00, 2'b11, 2'd3, 1'b1, 19'h7ffff}, 1'b0); // falling, channel 3
		push_word({8'hff, 2'b11, 2'd2, 1'b1, 19'h1234f}, 1'b0); // falling, no rising seen
		push_word({8'h00, 2'b10, 15'h0000, 7'd19}, 1'b0);     // largest plain error id
		push_word({8'h00, 2'b10, 15'h0000, 7'd20}, 1'b0);     // clamped error id
		push_word(32'hff80007f, 1'b0);
		push_word({tdcmu_pkg::MARK_CHIP1, 16'hffff}, 1'b0);
		push_word({8'h00, 2'b11, 2'd1, 1'b0, 19'h55555}, 1'b0); // chip 1, epoch cleared
		push_word({tdcmu_pkg::MARK_DESEL_A, 16'h1234}, 1'b0);
		push_word(32'h00c00000, 1'b0);                       // no chip selected
		push_word({tdcmu_pkg::MARK_CHIP0, 16'h0000}, 1'b0);  // ignored in faulted buffer
		push_word({tdcmu_pkg::MARK_CHIP1, 16'h0001}, 1'b1);
		push_word({8'hff, 2'b01, 22'h3fffff}, 1'b0);         // unknown type in 24-bit format
		push_word({tdcmu_pkg::MARK_DESEL_B, 16'hffff}, 1'b1);
		drain();

		// 32-bit format, largest multiplier
		write_reg(tdcmu_pkg::CFG_MODE, 8'd1);
		write_reg(tdcmu_pkg::CFG_TOT_MULT, 8'd255);
		setting_count++;
		push_word({tdcmu_pkg::MARK_CHIP1, 16'hffff}, 1'b1);
		push_word(32'h01fffffe, 1'b0);                       // largest 24-bit epoch
		push_word({2'b11, 1'b1, 2'd3, 19'h7ffff, 8'hff}, 1'b0);
		push_word({2'b11, 1'b0, 2'd0, 19'h00000, 8'h00}, 1'b0);
		push_word({2'b01, 30'h3fffffff}, 1'b0);              // slow control
		push_word({2'b10, 23'h000000, 7'd5}, 1'b0);
		push_word(32'h00000000, 1'b0);                       // zero epoch
		push_word({2'b11, 1'b0, 2'd2, 19'h2aaaa, 8'h81}, 1'b0);
		drain();

		// Random buffers under a range of settings
		for (int p = 0; p < PHASES; p++) begin
			idle_mode = (p < 3) ? 0 : ((p < 6) ? 1 : 2);
			write_reg(tdcmu_pkg::CFG_MODE, {7'd0, PH_MODE[p]});
			write_reg(tdcmu_pkg::CFG_TOT_MULT, PH_MULT[p]);
			write_reg(tdcmu_pkg::CFG_CHIP_MASK, {6'd0, PH_MASK[p]});
			setting_count++;
			fill_phase(PHASE_WORDS, mode32);
			drain();
		end

		$display("%0d words under %0d register settings: %0d hits, %0d with time over threshold",
			words_in, setting_count, hit_count, tot_count);
		$display("%0d error messages and %0d buffer faults decoded, %0d check failures",
			err_count, fault_count, fail_count);
		if (fail_count == 0) begin
			$display("[tdc_message_unpacker] OK");
		end else begin
			$display("[tdc_message_unpacker] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
